// ----- hw/rtl/pte_pkg.sv -----
// pte_pkg: shared field widths and action codes for the prefix trie engine.
// No dependencies; imported by the channel interfaces and the core.
package pte_pkg;

  localparam int ACTION_W    = 2;
  localparam int LETTER_W    = 5;
  localparam int END_COUNT_W = 16;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EXACT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PREFIX = 2'd2;

endpackage

// ----- hw/rtl/pte_req_if.sv -----
// pte_req_if: request channel carrying one letter of a string per transfer.
// Depends on pte_pkg for field widths.
interface pte_req_if;
  import pte_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [LETTER_W-1:0] letter;
  logic                is_last;
  logic                empty_string;

  modport source (output valid, action, letter, is_last, empty_string, input ready);
  modport sink   (input valid, action, letter, is_last, empty_string, output ready);
endinterface

// ----- hw/rtl/pte_rsp_if.sv -----
// pte_rsp_if: response channel carrying one result per completed string.
// Depends on pte_pkg for field widths.
interface pte_rsp_if;
  import pte_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic                   pool_full;
  logic [END_COUNT_W-1:0] end_count;

  modport source (output valid, found, pool_full, end_count, input ready);
  modport sink   (input valid, found, pool_full, end_count, output ready);
endinterface

// ----- hw/rtl/prefix_trie_engine_core.sv -----
// Prefix trie engine: insert, exact search and prefix search over a node pool.
// A letter passes through ST_IDLE, which accepts it and reads the child table, and then
// ST_LOOK, which uses the registered read data and, for an insert needing a fresh node,
// writes the new child entry. The letter that ends a string then goes to ST_RESULT, which
// waits for the response channel and completes the end-count read-modify-write; an item
// that does not step (empty string, failed walk, pool overflow, letter out of range)
// skips ST_LOOK and goes straight to ST_RESULT if it ends the string. After reset the
// block clears both memories and accepts no request until that pass is done.
// Depends on pte_pkg, pte_req_if, pte_rsp_if and pte_ram.
module prefix_trie_engine_core #(
  parameter int NODE_POOL     = 1024,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 16
) (
  input  logic     clk,
  input  logic     rst,
  pte_req_if.sink  req,
  pte_rsp_if.source rsp
);
  import pte_pkg::*;

  localparam int NB       = $clog2(NODE_POOL);
  localparam int CT_DEPTH = NODE_POOL * ALPHABET_SIZE;
  localparam int CA_W     = $clog2(CT_DEPTH);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_RESULT} state_t;

  state_t                state;
  logic [CA_W-1:0]       clr_addr;
  logic [NB-1:0]         cur;
  logic [NB-1:0]         nodes_used;
  logic                  walk_failed;
  logic                  overflowed;
  logic [ACTION_W-1:0]   act_q;
  logic                  last_q;
  logic [CA_W-1:0]       slot_q;

  logic                  ct_we;
  logic [CA_W-1:0]       ct_waddr;
  logic [NB-1:0]         ct_wdata;
  logic                  ct_re;
  logic [CA_W-1:0]       ct_raddr;
  logic [NB-1:0]         ct_rdata;
  logic                  ec_we;
  logic [NB-1:0]         ec_waddr;
  logic [COUNT_BITS-1:0] ec_wdata;
  logic                  ec_re;
  logic [NB-1:0]         ec_raddr;
  logic [COUNT_BITS-1:0] ec_rdata;

  logic                  in_range;
  logic                  stepping;
  logic                  walk_ok;
  logic                  ends;
  logic                  out_free;

  logic                  look_hit;
  logic                  pool_end;
  logic                  grow;
  logic [NB-1:0]         alloc;
  logic [NB-1:0]         cur_next;
  logic                  fail_next;
  logic                  ovf_next;

  logic                  ok;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  res_found;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_upd;
  logic [COUNT_BITS+END_COUNT_W-1:0] cnt_ext;

  pte_ram #(.WIDTH(NB), .DEPTH(CT_DEPTH)) u_child_ram (
    .clk   (clk),
    .we    (ct_we),
    .waddr (ct_waddr),
    .wdata (ct_wdata),
    .re    (ct_re),
    .raddr (ct_raddr),
    .rdata (ct_rdata)
  );

  pte_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_POOL)) u_count_ram (
    .clk   (clk),
    .we    (ec_we),
    .waddr (ec_waddr),
    .wdata (ec_wdata),
    .re    (ec_re),
    .raddr (ec_raddr),
    .rdata (ec_rdata)
  );

  assign req.ready = (state == ST_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  assign in_range = (32'(req.letter) < 32'(ALPHABET_SIZE));
  assign stepping = !req.empty_string && !walk_failed && !overflowed;
  assign walk_ok  = stepping && in_range;
  assign ends     = req.is_last || req.empty_string;
  assign ct_raddr = CA_W'(cur) * CA_W'(ALPHABET_SIZE) + CA_W'(req.letter);

  // step along the child entry read for the current letter
  always_comb begin
    look_hit  = (ct_rdata != '0);
    pool_end  = (nodes_used == NB'(NODE_POOL - 1));
    alloc     = nodes_used + NB'(1);
    cur_next  = cur;
    fail_next = walk_failed;
    ovf_next  = overflowed;
    grow      = 1'b0;
    if (look_hit) begin
      cur_next = ct_rdata;
    end else if (act_q != ACT_INSERT) begin
      fail_next = 1'b1;
    end else if (pool_end) begin
      ovf_next = 1'b1;
    end else begin
      grow     = 1'b1;
      cur_next = alloc;
    end
  end

  // end-of-string result from the reached node's count
  always_comb begin
    ok      = !walk_failed && !overflowed;
    cnt_inc = (ec_rdata != '1) ? ec_rdata + COUNT_BITS'(1) : ec_rdata;
    res_upd = 1'b0;
    unique case (act_q)
      ACT_INSERT: begin
        res_found = ok;
        res_cnt   = cnt_inc;
        res_upd   = ok;
      end
      ACT_EXACT: begin
        res_found = ok && (ec_rdata != '0);
        res_cnt   = ec_rdata;
      end
      default: begin
        res_found = ok;
        res_cnt   = ec_rdata;
      end
    endcase
    cnt_ext = {{END_COUNT_W{1'b0}}, (res_found ? res_cnt : {COUNT_BITS{1'b0}})};
  end

  always_comb begin
    ct_we    = (state == ST_CLEAR) || ((state == ST_LOOK) && grow);
    ct_waddr = (state == ST_CLEAR) ? clr_addr : slot_q;
    ct_wdata = (state == ST_CLEAR) ? '0 : alloc;
    ct_re    = (state == ST_IDLE) && req.valid && walk_ok;

    ec_we    = ((state == ST_CLEAR) && (clr_addr < CA_W'(NODE_POOL))) ||
               ((state == ST_RESULT) && out_free && res_upd);
    ec_waddr = (state == ST_CLEAR) ? clr_addr[NB-1:0] : cur;
    ec_wdata = (state == ST_CLEAR) ? '0 : cnt_inc;
    ec_re    = ((state == ST_IDLE) && req.valid && !walk_ok && ends) ||
               ((state == ST_LOOK) && last_q);
    ec_raddr = (state == ST_LOOK) ? cur_next : cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      cur         <= '0;
      nodes_used  <= '0;
      walk_failed <= 1'b0;
      overflowed  <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !((state == ST_RESULT) && out_free)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == CA_W'(CT_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + CA_W'(1);
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            act_q  <= req.action;
            last_q <= ends;
            slot_q <= ct_raddr;
            if (walk_ok) begin
              state <= ST_LOOK;
            end else begin
              if (stepping) begin
                walk_failed <= 1'b1;
              end
              if (ends) begin
                state <= ST_RESULT;
              end
            end
          end
        end
        ST_LOOK: begin
          cur         <= cur_next;
          walk_failed <= fail_next;
          overflowed  <= ovf_next;
          if (grow) begin
            nodes_used <= alloc;
          end
          state <= last_q ? ST_RESULT : ST_IDLE;
        end
        ST_RESULT: begin
          if (out_free) begin
            rsp.valid     <= 1'b1;
            rsp.found     <= res_found;
            rsp.pool_full <= overflowed;
            rsp.end_count <= cnt_ext[END_COUNT_W-1:0];
            cur           <= '0;
            walk_failed   <= 1'b0;
            overflowed    <= 1'b0;
            state         <= ST_IDLE;
          end
        end
      endcase
    end
  end

  a_alloc_moves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) && ct_we |=> (cur == nodes_used))
    else $error("walk did not move to the freshly allocated node");

  a_cur_bound: assert property (@(posedge clk) disable iff (rst)
    cur <= nodes_used)
    else $error("current node beyond allocated nodes");

  a_pool_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> nodes_used >= $past(nodes_used))
    else $error("allocated node count decreased");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.pool_full))
    else $error("result reports both found and pool full");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> (rsp.end_count == '0))
    else $error("nonzero end count on a miss");

endmodule

// ----- hw/rtl/pte_ram.sv -----
// pte_ram: generic single-write, single-read synchronous RAM.
// Read data is registered and holds while no read is enabled. No dependencies.
module pte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/prefix_trie_engine_core_tb.sv -----
// Self-checking bench for prefix_trie_engine_core: letters go in as request transfers and
// each string's result is checked against a trie tracker kept in the bench.
// Depends on pte_pkg, pte_req_if, pte_rsp_if and the core.
module prefix_trie_engine_core_tb;
  import pte_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic                   found;
    logic                   pool_full;
    logic [END_COUNT_W-1:0] end_count;
  } trie_answer_t;

  class trie_book #(int POOL = 1024, int ALPHA = 26, int CBITS = 16);
    int unsigned  child_of[POOL*ALPHA];
    int unsigned  ends[POOL];
    int unsigned  nodes_used;
    int unsigned  here;
    bit           lost;
    bit           overflowed;
    trie_answer_t answers[$];
    int           errors;

    function new();
      foreach (child_of[i]) child_of[i] = 0;
      foreach (ends[i]) ends[i] = 0;
      nodes_used = 0;
      here = 0;
      lost = 1'b0;
      overflowed = 1'b0;
      errors = 0;
    endfunction

    function void note(logic [ACTION_W-1:0] act, logic [LETTER_W-1:0] letter, logic last,
                       logic empty);
      int unsigned slot;
      int unsigned nxt;
      int unsigned c;
      int unsigned cmax;
      trie_answer_t ans;
      cmax = 32'((64'd1 << CBITS) - 64'd1);
      if (!empty && !lost && !overflowed) begin
        if (letter >= ALPHA) begin
          lost = 1'b1;
        end else begin
          slot = here * ALPHA + letter;
          nxt = child_of[slot];
          if (nxt == 0 && act != ACT_INSERT) begin
            lost = 1'b1;
          end else if (nxt == 0 && nodes_used + 1 >= POOL) begin
            overflowed = 1'b1;
          end else begin
            if (nxt == 0) begin
              nodes_used++;
              nxt = nodes_used;
              child_of[slot] = nxt;
            end
            here = nxt;
          end
        end
      end
      if (!(last || empty)) return;
      ans = '0;
      ans.pool_full = overflowed;
      if (!lost && !overflowed) begin
        c = ends[here];
        if (act == ACT_INSERT) begin
          if (c < cmax) c++;
          ends[here] = c;
          ans.found = 1'b1;
        end else if (act == ACT_EXACT) begin
          ans.found = (c != 0);
        end else begin
          ans.found = 1'b1;
        end
        if (ans.found) ans.end_count = c[END_COUNT_W-1:0];
      end
      answers = {answers, ans};
      here = 0;
      lost = 1'b0;
      overflowed = 1'b0;
    endfunction

    function void check(logic found, logic pool_full, logic [END_COUNT_W-1:0] end_count);
      trie_answer_t want;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result found=%0b pool_full=%0b end_count=%0d",
                 $time, found, pool_full, end_count);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, found);
        errors++;
      end
      if (pool_full !== want.pool_full) begin
        $display("%0t: pool_full expected %0b actual %0b", $time, want.pool_full, pool_full);
        errors++;
      end
      if (end_count !== want.end_count) begin
        $display("%0t: end_count expected %0d actual %0d", $time, want.end_count, end_count);
        errors++;
      end
    endfunction
  endclass

  localparam int NODE_POOL     = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int COUNT_BITS    = 16;
  localparam int LEX_N         = 128;
  localparam int MAX_LEN       = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT         = 2000000;

  logic clk;
  logic rst;
  bit   no_idle;
  bit   hold_req;
  int   items_sent;
  int   lex_n;
  int   lex_len[LEX_N];
  logic [LETTER_W-1:0] lex[LEX_N][MAX_LEN];
  logic [LETTER_W-1:0] spell[MAX_LEN];
  int unsigned cycles;

  trie_book #(NODE_POOL, ALPHABET_SIZE, COUNT_BITS) book;

  pte_req_if req_ch();
  pte_rsp_if rsp_ch();

  prefix_trie_engine_core #(
    .NODE_POOL    (NODE_POOL),
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .COUNT_BITS   (COUNT_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int fresh_word(int lo, int hi);
    int len;
    int k;
    len = $urandom_range(lo, hi);
    for (int i = 0; i < len; i++) spell[i] = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
    if (lex_n < LEX_N) begin
      k = lex_n;
      lex_n = lex_n + 1;
    end else begin
      k = $urandom_range(0, LEX_N - 1);
    end
    lex_len[k] = len;
    for (int i = 0; i < len; i++) lex[k][i] = spell[i];
    return len;
  endfunction

  function automatic int load_word();
    int k;
    k = $urandom_range(0, lex_n - 1);
    for (int i = 0; i < lex_len[k]; i++) spell[i] = lex[k][i];
    return lex_len[k];
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic drive_item(logic [ACTION_W-1:0] act, logic [LETTER_W-1:0] letter,
                            logic last, logic empty);
    int n;
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.letter       <= letter;
    req_ch.is_last      <= last;
    req_ch.empty_string <= empty;
    do @(posedge clk); while (!req_ch.ready);
    book.note(act, letter, last, empty);
    items_sent++;
    @(negedge clk);
    n = no_idle ? 0 : pick_gap();
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_string(logic [ACTION_W-1:0] act, int len, bit mixed);
    bit close_empty;
    logic [ACTION_W-1:0] a;
    close_empty = (len == 0) || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      a = mixed ? ACTION_W'($urandom_range(0, 3)) : act;
      drive_item(a, spell[i], !close_empty && i == len - 1, 1'b0);
    end
    if (close_empty) begin
      a = mixed ? ACTION_W'($urandom_range(0, 3)) : act;
      drive_item(a, LETTER_W'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  task automatic random_string();
    int r;
    int len;
    bit mixed;
    logic [ACTION_W-1:0] act;
    r = (lex_n == 0) ? 0 : $urandom_range(0, 99);
    mixed = 1'b0;
    if (r < 35) begin
      act = ACT_INSERT;
      len = (lex_n > 0 && $urandom_range(0, 1) == 1) ? load_word() : fresh_word(1, 8);
    end else if (r < 55) begin
      act = ACT_EXACT;
      len = load_word();
      if ($urandom_range(0, 3) == 0) len = $urandom_range(0, len);
    end else if (r < 70) begin
      act = ACT_PREFIX;
      len = $urandom_range(0, load_word());
    end else if (r < 80) begin
      act = ACTION_W'($urandom_range(1, 3));
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) spell[i] = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
    end else if (r < 90) begin
      act = ACTION_W'($urandom_range(0, 3));
      mixed = 1'b1;
      len = load_word();
    end else begin
      act = ACTION_W'($urandom_range(0, 3));
      mixed = 1'b1;
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) spell[i] = LETTER_W'($urandom_range(0, 31));
    end
    send_string(act, len, mixed);
    if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
  endtask

  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (no_idle) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          rsp_ch.ready <= 1'b1;
        end else begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(negedge clk);
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      book.check(rsp_ch.found, rsp_ch.pool_full, rsp_ch.end_count);
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("prefix_trie_engine_core_tb: errors");
    $finish;
  end

  initial begin
    int start;
    int n;
    int len;
    book = new();
    rst = 1'b1;
    no_idle = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    lex_n = 0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_INSERT;
    req_ch.letter = '0;
    req_ch.is_last = 1'b0;
    req_ch.empty_string = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    drive_item(ACT_EXACT, 5'd0, 1'b1, 1'b1);
    drive_item(ACT_PREFIX, 5'd31, 1'b0, 1'b1);
    drive_item(ACT_INSERT, 5'd0, 1'b1, 1'b0);
    drive_item(ACT_INSERT, 5'd25, 1'b0, 1'b0);
    drive_item(ACT_INSERT, 5'd24, 1'b1, 1'b0);
    drive_item(ACT_EXACT, 5'd25, 1'b1, 1'b0);
    drive_item(ACT_PREFIX, 5'd25, 1'b1, 1'b0);
    drive_item(ACT_EXACT, 5'd25, 1'b0, 1'b0);
    drive_item(ACT_EXACT, 5'd24, 1'b1, 1'b0);
    drive_item(ACT_SPARE, 5'd25, 1'b0, 1'b0);
    drive_item(ACT_SPARE, 5'd24, 1'b1, 1'b0);
    drive_item(ACT_EXACT, 5'd1, 1'b0, 1'b0);
    drive_item(ACT_EXACT, 5'd0, 1'b1, 1'b0);
    drive_item(ACT_INSERT, 5'd31, 1'b1, 1'b0);
    drive_item(ACT_PREFIX, 5'd26, 1'b1, 1'b0);
    drive_item(ACT_INSERT, 5'd25, 1'b0, 1'b0);
    drive_item(ACT_EXACT, 5'd23, 1'b1, 1'b0);
    drive_item(ACT_EXACT, 5'd25, 1'b0, 1'b0);
    drive_item(ACT_INSERT, 5'd23, 1'b1, 1'b0);
    drive_item(ACT_INSERT, 5'd25, 1'b0, 1'b0);
    drive_item(ACT_INSERT, 5'd0, 1'b0, 1'b1);
    drive_item(ACT_INSERT, 5'd16, 1'b0, 1'b0);
    drive_item(ACT_INSERT, 5'd15, 1'b0, 1'b0);
    drive_item(ACT_INSERT, 5'd31, 1'b0, 1'b0);
    drive_item(ACT_INSERT, 5'd7, 1'b1, 1'b0);

    start = items_sent;
    n = 0;
    while (items_sent - start < 400) begin
      random_string();
      n++;
      if (n == 15) hold_req = 1'b1;
    end
    while (book.nodes_used < NODE_POOL - 1) begin
      len = fresh_word(6, MAX_LEN);
      send_string(ACT_INSERT, len, 1'b0);
    end
    repeat (80) random_string();
    req_ch.valid <= 1'b0;

    while (book.answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0)
      $display("prefix_trie_engine_core_tb: clean");
    else
      $display("prefix_trie_engine_core_tb: errors");
    $finish;
  end
endmodule
